FILE: rtl/core/lfbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbl_pkg
// Shared types and constants of the LED frame brightness limiter with dither.
// ----------------------------------------------------------------------------
package lfbl_pkg;

   // transaction kinds
   localparam logic [1:0] KIND_TABLE = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // gamma table channels
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_NONE  = 2'd3;

   localparam int          DEF_MAX_PIXELS = 1024;
   localparam logic [8:0]  MB_RESET       = 9'd256;
   // three channels of full scale 255
   localparam logic [9:0]  LEVEL_FULL     = 10'd765;
   localparam logic [16:0] SCALE_ONE      = 17'd65536;
   localparam int          QUOT_W         = 16;

   // lane control
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic dit_en;
   } lane_ctrl_type;

   // gamma read request
   typedef struct packed {
      logic       en;
      logic [7:0] addr_red;
      logic [7:0] addr_green;
      logic [7:0] addr_blue;
   } gamma_rd_type;

endpackage

FILE: rtl/core/led_frame_brightness_limit_dither_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_brightness_limit_dither_top
// Gamma map, frame brightness limit and error-diffusion dither for LED frames.
// A table write completes in idle; a pixel passes the sum state, a frame-end
// pixel also the limit multiply and compare and, when the limit applies, the
// bit-serial divider. Readout: result registered through frame store read,
// gamma read, scale multiply and dither; next request taken once it loads; a
// stalled earlier response holds the dither stage. One transaction at a time.
// Reset: synchronous; control, sums, residues cleared, scale one, ceiling 256.
// Gamma and frame stores are not cleared and hold nothing valid until written.
// ----------------------------------------------------------------------------
module led_frame_brightness_limit_dither_top
   import lfbl_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_table_channel,
   input  logic [7:0]  req_table_index,
   input  logic [15:0] req_table_value,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_last_pixel
);

   localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = $clog2(longint'(MAX_PIXELS) * 196605 + 1);
   localparam int LIM_W = $clog2(longint'(MAX_PIXELS) * 390915 + 1);
   localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_PIX_SUM = 8'b0000_0010,
      ST_LIM_MUL = 8'b0000_0100,
      ST_LIM_CMP = 8'b0000_1000,
      ST_DIV_RUN = 8'b0001_0000,
      ST_RD_TBL  = 8'b0010_0000,
      ST_RD_MUL  = 8'b0100_0000,
      ST_RD_DIT  = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [8:0]         mb_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rp_ff, rp_in;
   logic [16:0]        scale_ff, scale_in;
   logic               ready_ff, ready_in;
   logic [LIM_W-1:0]   limit_ff;
   logic               stored_ff, fe_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         out_red_ff, out_green_ff, out_blue_ff;
   logic               last_ff;

   logic               accept;
   logic               is_table, is_pixel, is_read;
   logic               store_ok, read_ok;
   logic               load;
   logic               div_start, div_done;
   logic [QUOT_W-1:0]  div_quot;
   gamma_rd_type       grd;
   lane_ctrl_type      lctl;
   logic [15:0]        g_red, g_green, g_blue;
   logic [23:0]        frame_rd;
   logic [AW-1:0]      frame_wr_addr;
   logic [17:0]        mapped_sum;
   logic [7:0]         lvl_red, lvl_green, lvl_blue;

   // transaction decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_table  = (req_kind == KIND_TABLE);
   assign is_pixel  = (req_kind == KIND_PIXEL);
   assign is_read   = (req_kind == KIND_READ);
   // a pixel on a ready frame starts a new frame at slot zero
   assign store_ok  = ready_ff || (count_ff < CNT_W'(MAX_PIXELS));
   assign read_ok   = ready_ff && (rp_ff < count_ff);
   assign frame_wr_addr = ready_ff ? '0 : count_ff[AW-1:0];
   assign load      = (state_ff == ST_RD_DIT) && (!rsp_valid_ff || !rsp_stall);

   // gamma read address select
   always_comb begin
      grd.en         = (accept && is_pixel) || (state_ff == ST_RD_TBL);
      grd.addr_red   = (state_ff == ST_RD_TBL) ? frame_rd[23:16] : req_red;
      grd.addr_green = (state_ff == ST_RD_TBL) ? frame_rd[15:8]  : req_green;
      grd.addr_blue  = (state_ff == ST_RD_TBL) ? frame_rd[7:0]   : req_blue;
   end

   always_comb begin
      lctl.clear  = accept && is_pixel;
      lctl.mul_en = (state_ff == ST_RD_MUL);
      lctl.dit_en = load;
   end

   assign mapped_sum = 18'(g_red) + 18'(g_green) + 18'(g_blue);
   assign div_start  = (state_ff == ST_LIM_CMP) && (CMP_W'(sum_ff) > CMP_W'(limit_ff));

   lfbl_gamma_mem u_gamma (
      .clock    (clock),
      .wr_en    (accept && is_table && (req_table_channel != CH_NONE)),
      .wr_chan  (req_table_channel),
      .wr_idx   (req_table_index),
      .wr_data  (req_table_value),
      .rd       (grd),
      .rd_red   (g_red),
      .rd_green (g_green),
      .rd_blue  (g_blue)
   );

   lfbl_frame_mem #(.DEPTH(MAX_PIXELS), .AW(AW)) u_frame (
      .clock   (clock),
      .wr_en   (accept && is_pixel && store_ok),
      .wr_addr (frame_wr_addr),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (accept && is_read && read_ok),
      .rd_addr (rp_ff[AW-1:0]),
      .rd_data (frame_rd)
   );

   lfbl_divider #(.SUM_W(SUM_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SUM_W'(limit_ff)),
      .divisor  (sum_ff),
      .done     (div_done),
      .quot     (div_quot)
   );

   lfbl_lane u_lane_red (
      .clock (clock), .reset (reset), .ctrl (lctl),
      .mapped (g_red), .scale (scale_ff), .level (lvl_red)
   );

   lfbl_lane u_lane_green (
      .clock (clock), .reset (reset), .ctrl (lctl),
      .mapped (g_green), .scale (scale_ff), .level (lvl_green)
   );

   lfbl_lane u_lane_blue (
      .clock (clock), .reset (reset), .ctrl (lctl),
      .mapped (g_blue), .scale (scale_ff), .level (lvl_blue)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rp_in        = rp_ff;
      scale_in     = scale_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_pixel) begin
               if (ready_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  rp_in    = '0;
                  ready_in = 1'b0;
               end
               state_in = ST_PIX_SUM;
            end else if (accept && is_read && read_ok) begin
               state_in = ST_RD_TBL;
            end
         end
         ST_PIX_SUM: begin
            if (stored_ff) begin
               sum_in   = sum_ff + SUM_W'(mapped_sum);
               count_in = count_ff + CNT_W'(1);
            end
            state_in = fe_ff ? ST_LIM_MUL : ST_IDLE;
         end
         ST_LIM_MUL: state_in = ST_LIM_CMP;
         ST_LIM_CMP: begin
            if (div_start) begin
               state_in = ST_DIV_RUN;
            end else begin
               scale_in = SCALE_ONE;
               ready_in = 1'b1;
               rp_in    = '0;
               state_in = ST_IDLE;
            end
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               scale_in = 17'(div_quot);
               ready_in = 1'b1;
               rp_in    = '0;
               state_in = ST_IDLE;
            end
         end
         ST_RD_TBL: state_in = ST_RD_MUL;
         ST_RD_MUL: state_in = ST_RD_DIT;
         ST_RD_DIT: begin
            if (load) begin
               rp_in        = rp_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mb_ff        <= MB_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         rp_ff        <= '0;
         scale_ff     <= SCALE_ONE;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) mb_ff <= csr_wr_data;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rp_ff        <= rp_in;
         scale_ff     <= scale_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept && is_pixel) begin
         stored_ff <= store_ok;
         fe_ff     <= req_frame_end;
      end
      if (state_ff == ST_LIM_MUL)
         limit_ff <= LIM_W'(mb_ff) * LIM_W'(LEVEL_FULL) * LIM_W'(count_ff);
      if (load) begin
         out_red_ff   <= lvl_red;
         out_green_ff <= lvl_green;
         out_blue_ff  <= lvl_blue;
         last_ff      <= (rp_ff + CNT_W'(1)) == count_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = out_red_ff;
   assign rsp_out_green  = out_green_ff;
   assign rsp_out_blue   = out_blue_ff;
   assign rsp_last_pixel = last_ff;

   // checks
   a_read_needs_frame: assert property (@(posedge clock) disable iff (reset)
      load |-> ready_ff)
      else $error("readout result without a ready frame");

   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      scale_ff[16] |-> (scale_ff[15:0] == '0))
      else $error("limiting factor above one");

   a_read_pos: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= count_ff)
      else $error("read position past pixel count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count past capacity");

endmodule

FILE: rtl/core/lfbl_gamma_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbl_gamma_mem
// Three 256 x 16 gamma banks, one write port, one registered read per bank.
// ----------------------------------------------------------------------------
module lfbl_gamma_mem
   import lfbl_pkg::*;
(
   input  logic         clock,
   input  logic         wr_en,
   input  logic [1:0]   wr_chan,
   input  logic [7:0]   wr_idx,
   input  logic [15:0]  wr_data,
   input  gamma_rd_type rd,
   output logic [15:0]  rd_red,
   output logic [15:0]  rd_green,
   output logic [15:0]  rd_blue
);

   logic [15:0] bank_red_ff   [256];
   logic [15:0] bank_green_ff [256];
   logic [15:0] bank_blue_ff  [256];
   logic [15:0] rd_red_ff, rd_green_ff, rd_blue_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en && wr_chan == CH_RED)   bank_red_ff[wr_idx]   <= wr_data;
      if (wr_en && wr_chan == CH_GREEN) bank_green_ff[wr_idx] <= wr_data;
      if (wr_en && wr_chan == CH_BLUE)  bank_blue_ff[wr_idx]  <= wr_data;
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_red_ff   <= bank_red_ff[rd.addr_red];
         rd_green_ff <= bank_green_ff[rd.addr_green];
         rd_blue_ff  <= bank_blue_ff[rd.addr_blue];
      end
   end

   assign rd_red   = rd_red_ff;
   assign rd_green = rd_green_ff;
   assign rd_blue  = rd_blue_ff;

endmodule

FILE: rtl/core/lfbl_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbl_frame_mem
// Raw pixel store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lfbl_frame_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data
);

   logic [23:0] store_ff [DEPTH];
   logic [23:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lfbl_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbl_divider
// Restoring divider, one quotient bit a cycle: floor(dividend * 2^16 / divisor)
// for dividend below divisor.
// ----------------------------------------------------------------------------
module lfbl_divider
   import lfbl_pkg::*;
#(
   parameter int SUM_W = 28
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [SUM_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quot
);

   localparam int CW = $clog2(QUOT_W);

   logic [SUM_W:0]    rem_ff;
   logic [SUM_W-1:0]  div_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff, done_ff;
   logic [SUM_W:0]    shifted, diff;
   logic              ge;

   // one restoring step
   always_comb begin
      shifted = {rem_ff[SUM_W-1:0], 1'b0};
      ge      = shifted >= {1'b0, div_ff};
      diff    = shifted - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff : shifted;
         quot_ff <= {quot_ff[QUOT_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

FILE: rtl/core/lfbl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfbl_lane
// One colour lane: scale by the limiting factor, round, error diffusion and
// saturation. Holds the lane's residue.
// ----------------------------------------------------------------------------
module lfbl_lane
   import lfbl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  logic [15:0]   mapped,
   input  logic [16:0]   scale,
   output logic [7:0]    level
);

   logic [32:0]        prod_ff;
   logic signed [8:0]  residue_ff;
   logic signed [8:0]  residue_in;
   logic [33:0]        psum;
   logic [16:0]        target;
   logic [9:0]         actual;
   logic signed [8:0]  err;
   logic signed [9:0]  acc;
   logic               corr_pos, corr_neg;
   logic signed [10:0] outv;

   // scale product
   always_ff @(posedge clock) begin
      if (ctrl.mul_en) prod_ff <= 33'(mapped) * 33'(scale);
   end

   // rounding and diffusion
   always_comb begin
      psum     = {1'b0, prod_ff} + 34'd32768;
      target   = psum[32:16];
      // half up to integer; error is the low byte taken as signed
      actual   = 10'(target[16:8]) + 10'(target[7]);
      err      = $signed({target[7], target[7:0]});
      acc      = 10'(residue_ff) + 10'(err);
      corr_pos = !acc[9] && (acc >= 10'sd128);
      corr_neg = acc[9] && (acc <= -10'sd128);
      outv     = $signed({1'b0, actual});
      residue_in = residue_ff;
      if (corr_pos) begin
         outv       = outv + 11'sd1;
         residue_in = 9'(acc - 10'sd256);
      end else if (corr_neg) begin
         outv       = outv - 11'sd1;
         residue_in = 9'(acc + 10'sd256);
      end else begin
         residue_in = 9'(acc);
      end
      // saturate to 0..255
      if (outv < 11'sd0)       level = 8'd0;
      else if (outv > 11'sd255) level = 8'd255;
      else                     level = outv[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) residue_ff <= '0;
      else if (ctrl.dit_en)    residue_ff <= residue_in;
   end

endmodule

FILE: dv/led_frame_brightness_limit_dither_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_brightness_limit_dither_checker
// Watches the request, response and CSR ports of the brightness limiter,
// predicts each readout pixel (gamma map, frame limit, dither) and compares
// every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module led_frame_brightness_limit_dither_checker
   import lfbl_pkg::*;
#(
   parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_table_channel,
   input  logic [7:0]  req_table_index,
   input  logic [15:0] req_table_value,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_red,
   input  logic [7:0]  rsp_out_green,
   input  logic [7:0]  rsp_out_blue,
   input  logic        rsp_last_pixel,
   output int          fail_count,
   output int          pixels_pending
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } led_pixel_type;

   // predictor state
   logic [15:0]   gamma_mem [768];
   logic [23:0]   frame_mem [MAX_PIXELS];
   logic [63:0]   sum_q;
   int unsigned   count_q;
   int unsigned   rd_pos_q;
   logic [31:0]   scale_q;
   int            residue_q [3];
   logic          ready_q;
   logic [8:0]    ceiling_q;
   led_pixel_type pixel_queue [$];

   assign pixels_pending = pixel_queue.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int round_half_away(input int e);
      if (e >= 0) return (e + 128) >>> 8;
      return -((-e + 128) >>> 8);
   endfunction

   function automatic void clear_frame();
      sum_q    = '0;
      count_q  = 0;
      rd_pos_q = 0;
      ready_q  = 1'b0;
      for (int i = 0; i < 3; i++) residue_q[i] = 0;
   endfunction

   // one accepted transaction through the predictor
   function automatic void predict_transaction();
      logic [63:0]   limit;
      logic [63:0]   prod;
      logic [23:0]   raw;
      int            target;
      int            actual;
      int            corr;
      logic [7:0]    lvl;
      led_pixel_type px;
      logic [7:0]    res [3];
      case (req_kind)
         KIND_TABLE: begin
            if (req_table_channel != CH_NONE)
               gamma_mem[req_table_channel * 256 + req_table_index] = req_table_value;
         end
         KIND_PIXEL: begin
            if (ready_q) clear_frame();
            if (count_q < MAX_PIXELS) begin
               frame_mem[count_q] = {req_red, req_green, req_blue};
               sum_q = sum_q + gamma_mem[req_red] + gamma_mem[256 + req_green]
                       + gamma_mem[512 + req_blue];
               count_q++;
            end
            if (req_frame_end) begin
               limit = 64'(ceiling_q) * 765 * count_q;
               if (sum_q > limit) scale_q = 32'((limit << 16) / sum_q);
               else scale_q = 32'd65536;
               ready_q  = 1'b1;
               rd_pos_q = 0;
               for (int i = 0; i < 3; i++) residue_q[i] = 0;
            end
         end
         KIND_READ: begin
            if (ready_q && rd_pos_q < count_q) begin
               raw = frame_mem[rd_pos_q];
               for (int ch = 0; ch < 3; ch++) begin
                  lvl    = raw[16 - 8 * ch +: 8];
                  prod   = 64'(gamma_mem[ch * 256 + lvl]) * scale_q;
                  target = int'((prod + 32768) >> 16);
                  actual = (target + 128) >>> 8;
                  residue_q[ch] += target - actual * 256;
                  corr = round_half_away(residue_q[ch]);
                  actual += corr;
                  residue_q[ch] -= corr * 256;
                  if (actual < 0) actual = 0;
                  if (actual > 255) actual = 255;
                  res[ch] = 8'(actual);
               end
               rd_pos_q++;
               px.red   = res[0];
               px.green = res[1];
               px.blue  = res[2];
               px.last  = (rd_pos_q == count_q);
               pixel_queue.push_back(px);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      led_pixel_type want;
      if (reset) begin
         clear_frame();
         scale_q    = 32'd65536;
         ceiling_q  = MB_RESET;
         fail_count = 0;
         pixel_queue.delete();
      end else begin
         if (csr_wr_en) ceiling_q = csr_wr_data;
         if (req_valid && !req_stall) predict_transaction();
         // response compare
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               $display("UNEXPECTED response at %0t", $realtime);
               fail_count++;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_out_red != want.red) report_mismatch("red", rsp_out_red, want.red);
               if (rsp_out_green != want.green)
                  report_mismatch("green", rsp_out_green, want.green);
               if (rsp_out_blue != want.blue) report_mismatch("blue", rsp_out_blue, want.blue);
               if (rsp_last_pixel != want.last)
                  report_mismatch("last", rsp_last_pixel, want.last);
            end
         end
      end
   end

endmodule

FILE: dv/led_frame_brightness_limit_dither_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_brightness_limit_dither_top_tb
// Drives table loads, frames and readouts with random gaps and stalls across
// several brightness ceilings; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module led_frame_brightness_limit_dither_top_tb;
   import lfbl_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [8:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_TABLE;
   logic [1:0]  req_table_channel = CH_RED;
   logic [7:0]  req_table_index = '0;
   logic [15:0] req_table_value = '0;
   logic [7:0]  req_red = '0;
   logic [7:0]  req_green = '0;
   logic [7:0]  req_blue = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        rsp_last_pixel;
   int          fail_count;
   int          pixels_pending;
   int          idle_cycles = 0;
   int          frame_len = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   led_frame_brightness_limit_dither_top dut (.*);

   led_frame_brightness_limit_dither_checker checker_i (.*);

   // watchdog on cycles without any accepted request or response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response back-pressure
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) rsp_stall <= 1'b0;
      else if (r < 60) rsp_stall <= 1'b0;
      else if (r < 95) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 3) != 0);
   end

   // one transaction, held until accepted; valid drops only in a gap
   task automatic send(input logic [1:0] kind, input logic [1:0] tch, input logic [7:0] tidx,
                       input logic [15:0] tval, input logic [7:0] r, input logic [7:0] g,
                       input logic [7:0] b, input logic fe);
      int gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_table_channel <= tch;
      req_table_index   <= tidx;
      req_table_value   <= tval;
      req_red           <= r;
      req_green         <= g;
      req_blue          <= b;
      req_frame_end     <= fe;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_table(input logic [1:0] tch, input logic [7:0] tidx,
                             input logic [15:0] tval);
      send(KIND_TABLE, tch, tidx, tval, '0, '0, '0, 1'b0);
   endtask

   task automatic send_pixel(input logic fe);
      send(KIND_PIXEL, 2'($urandom), 8'($urandom), 16'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom), fe);
   endtask

   task automatic read_pixel();
      send(KIND_READ, 2'($urandom), 8'($urandom), 16'($urandom),
           8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
   endtask

   // ceiling write once idle
   task automatic set_ceiling(input logic [8:0] value);
      req_valid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int kind_pick;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every table entry so no undefined entry is ever read
      for (int ch = 0; ch < 3; ch++)
         for (int i = 0; i < 256; i++)
            load_table(2'(ch), 8'(i), 16'($urandom_range(0, 255 * 256)));

      // directed: a read with nothing ready, unused kind, ignored channel
      read_pixel();
      send(2'd3, '0, '0, '0, '0, '0, '0, 1'b1);
      load_table(CH_NONE, 8'd0, 16'hFFFF);
      // extremes of the table and of pixel levels
      load_table(CH_RED, 8'd255, 16'hFFFF);
      load_table(CH_GREEN, 8'd255, 16'hFFFF);
      load_table(CH_BLUE, 8'd255, 16'hFFFF);
      load_table(CH_RED, 8'd0, 16'h0000);
      load_table(CH_GREEN, 8'd0, 16'h0000);
      load_table(CH_BLUE, 8'd0, 16'h0000);
      send(KIND_PIXEL, '0, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0);
      send(KIND_PIXEL, '0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1);
      // table rewrite after frame end, then reads past the end
      load_table(CH_RED, 8'd255, 16'h8000);
      repeat (3) read_pixel();
      // zero-sum frame
      send(KIND_PIXEL, '0, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1);
      read_pixel();
      // a two-pixel frame read once, then a new frame abandoning its unread pixel
      send(KIND_PIXEL, '0, '0, '0, 8'd255, 8'd0, 8'd255, 1'b0);
      send(KIND_PIXEL, '0, '0, '0, 8'd255, 8'd255, 8'd0, 1'b1);
      read_pixel();
      send(KIND_PIXEL, '0, '0, '0, 8'd128, 8'd1, 8'd254, 1'b1);
      read_pixel();

      // random phases over several ceilings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_ceiling(9'd0);
            1: set_ceiling(9'd256);
            2: set_ceiling(9'd511);
            3: set_ceiling(9'd1);
            default: set_ceiling(9'($urandom_range(0, 511)));
         endcase
         for (int f = 0; f < 3; f++) begin
            // mostly short frames, one past capacity in the third phase
            if (phase == 2 && f == 0) frame_len = DEF_MAX_PIXELS + 3;
            else frame_len = $urandom_range(1, 12);
            for (int p = 0; p < frame_len; p++) begin
               kind_pick = $urandom_range(0, 99);
               if (kind_pick < 4) load_table(2'($urandom), 8'($urandom), 16'($urandom));
               else if (kind_pick < 6) send(2'd3, 2'($urandom), '0, '0, '0, '0, '0, 1'b0);
               send_pixel(p == frame_len - 1);
            end
            for (int r = 0; r < frame_len + $urandom_range(0, 2); r++) begin
               if (frame_len > 100 && r > 40) break;
               read_pixel();
            end
         end
      end

      req_valid <= 1'b0;
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
